### rtl/aisenc_pkg.sv
// Shared types, constants and character helpers for the AIS position report encoder.
package aisenc_pkg;

  localparam int unsigned MsgBits      = 168;
  localparam int unsigned SentLen      = 49;
  localparam int unsigned IdxW         = 6;
  localparam int unsigned InDataW      = 120;

  localparam logic signed [27:0] LonLimit = 28'sd108000000;
  localparam logic signed [27:0] LonNone  = 28'sd108600000;
  localparam logic signed [26:0] LatLimit = 27'sd54000000;
  localparam logic signed [26:0] LatNone  = 27'sd54600000;
  localparam logic [15:0] SogMax   = 16'd1022;
  localparam logic [9:0]  SogNone  = 10'd1023;
  localparam logic [11:0] CogNone  = 12'd3600;
  localparam logic [8:0]  HdgNone  = 9'd511;
  localparam logic [15:0] Recip10  = 16'd52429;

  typedef struct packed {
    logic [5:0]         utc_second;
    logic [11:0]        course_tenths;
    logic signed [26:0] lat_units;
    logic signed [27:0] lon_units;
    logic [15:0]        speed_tenths;
    logic [29:0]        vessel_id;
  } report_t;

  function automatic logic [7:0] head_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = "!";
      4'd1:    c = "A";
      4'd2:    c = "I";
      4'd3:    c = "V";
      4'd4:    c = "D";
      4'd5:    c = "M";
      4'd6:    c = ",";
      4'd7:    c = "1";
      4'd8:    c = ",";
      4'd9:    c = "1";
      4'd10:   c = ",";
      4'd11:   c = ",";
      4'd12:   c = "A";
      4'd13:   c = ",";
      default: c = ",";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] armor(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd40) begin
      c = {2'b00, v} + 8'd48;
    end else begin
      c = {2'b00, v} + 8'd56;
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'd48 + {4'b0000, n};
    end else begin
      c = 8'd55 + {4'b0000, n};
    end
    return c;
  endfunction

endpackage

### rtl/aisenc_pack.sv
// Builds the 168-bit AIS type 1 message from one registered vessel report.
module aisenc_pack (
  input  aisenc_pkg::report_t             rep_i,
  output logic [aisenc_pkg::MsgBits-1:0]  msg_o
);

  logic [9:0]         sog;
  logic signed [27:0] lon;
  logic signed [26:0] lat;
  logic [11:0]        cog;
  logic [27:0]        prod;
  logic [8:0]         hdg;

  always_comb begin
    if (rep_i.speed_tenths > aisenc_pkg::SogMax) begin
      sog = aisenc_pkg::SogNone;
    end else begin
      sog = rep_i.speed_tenths[9:0];
    end

    if (rep_i.lon_units < -aisenc_pkg::LonLimit || rep_i.lon_units > aisenc_pkg::LonLimit) begin
      lon = aisenc_pkg::LonNone;
    end else begin
      lon = rep_i.lon_units;
    end

    if (rep_i.lat_units < -aisenc_pkg::LatLimit || rep_i.lat_units > aisenc_pkg::LatLimit) begin
      lat = aisenc_pkg::LatNone;
    end else begin
      lat = rep_i.lat_units;
    end

    prod = {16'b0, rep_i.course_tenths} * {12'b0, aisenc_pkg::Recip10};
    if (rep_i.course_tenths >= aisenc_pkg::CogNone) begin
      cog = aisenc_pkg::CogNone;
      hdg = aisenc_pkg::HdgNone;
    end else begin
      cog = rep_i.course_tenths;
      hdg = prod[27:19];
    end

    msg_o = {6'd1, 2'd0, rep_i.vessel_id, 4'd0, 8'd0, sog, 1'b1, lon, lat, cog, hdg,
             rep_i.utc_second, 2'd0, 3'd0, 1'b0, 19'd0};
  end

endmodule

### rtl/ais_position_report_nmea_encoder.sv
// Top level: AIS type 1 position report to NMEA AIVDM sentence, one byte per word.
// Each report accepted on the slave side yields the 49-byte sentence
// "!AIVDM,1,1,,A,<28 payload chars>,0*HH" CR LF on the master side, one byte per
// cycle while m_axis_tready holds no stall, with tlast on the line feed. A report
// passes an input register, is packed into a 168-bit message register and is then
// shifted out through an output register while the checksum builds up byte by byte.
// The serialiser sets the pace: sentences follow with no gap when the next report
// is waiting, and it stays in the input register while the current sentence drains.
module ais_position_report_nmea_encoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vessel_id[29:0], speed_tenths[45:30], lon_units[73:46], lat_units[100:74],
  // course_tenths[112:101], utc_second[118:113], zero fill [119]
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_char[7:0]
  output logic [7:0]   m_axis_tdata,
  output logic         m_axis_tlast
);

  localparam int unsigned IdxW = aisenc_pkg::IdxW;
  localparam logic [IdxW-1:0] IdxFirstBody = 6'd1;
  localparam logic [IdxW-1:0] IdxPayload   = 6'd14;
  localparam logic [IdxW-1:0] IdxPayEnd    = 6'd41;
  localparam logic [IdxW-1:0] IdxComma     = 6'd42;
  localparam logic [IdxW-1:0] IdxZero      = 6'd43;
  localparam logic [IdxW-1:0] IdxStar      = 6'd44;
  localparam logic [IdxW-1:0] IdxHexHi     = 6'd45;
  localparam logic [IdxW-1:0] IdxHexLo     = 6'd46;
  localparam logic [IdxW-1:0] IdxCr        = 6'd47;
  localparam logic [IdxW-1:0] IdxLf        = 6'd48;

  logic                             in_valid_q;
  aisenc_pkg::report_t              in_rep_q;
  logic                             msg_valid_q;
  logic [aisenc_pkg::MsgBits-1:0]   msg_q;
  logic [aisenc_pkg::MsgBits-1:0]   msg_packed;
  logic [IdxW-1:0]                  idx_q;
  logic [7:0]                       sum_q;
  logic                             out_valid_q;
  logic [7:0]                       out_char_q;
  logic                             out_last_q;

  logic       out_free;
  logic       emit;
  logic       msg_done;
  logic       msg_load;
  logic [7:0] cur_char;

  aisenc_pack u_pack (
    .rep_i (in_rep_q),
    .msg_o (msg_packed)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign emit          = msg_valid_q && out_free;
  assign msg_done      = emit && (idx_q == IdxLf);
  assign msg_load      = in_valid_q && (!msg_valid_q || msg_done);
  assign s_axis_tready = !in_valid_q || msg_load;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    if (idx_q < IdxPayload) begin
      cur_char = aisenc_pkg::head_char(idx_q[3:0]);
    end else if (idx_q <= IdxPayEnd) begin
      cur_char = aisenc_pkg::armor(msg_q[aisenc_pkg::MsgBits-1 -: 6]);
    end else begin
      case (idx_q)
        IdxComma: cur_char = ",";
        IdxZero:  cur_char = "0";
        IdxStar:  cur_char = "*";
        IdxHexHi: cur_char = aisenc_pkg::hex_digit(sum_q[7:4]);
        IdxHexLo: cur_char = aisenc_pkg::hex_digit(sum_q[3:0]);
        IdxCr:    cur_char = 8'h0D;
        default:  cur_char = 8'h0A;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      msg_valid_q <= 1'b0;
      idx_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (msg_load) begin
        in_valid_q <= 1'b0;
      end

      if (msg_load) begin
        msg_valid_q <= 1'b1;
        idx_q       <= '0;
        sum_q       <= '0;
      end else if (emit) begin
        if (msg_done) begin
          msg_valid_q <= 1'b0;
          idx_q       <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
        if (idx_q >= IdxFirstBody && idx_q <= IdxZero) begin
          sum_q <= sum_q ^ cur_char;
        end
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_rep_q <= aisenc_pkg::report_t'(s_axis_tdata[118:0]);
    end
    if (msg_load) begin
      msg_q <= msg_packed;
    end else if (emit && idx_q >= IdxPayload && idx_q <= IdxPayEnd) begin
      msg_q <= {msg_q[aisenc_pkg::MsgBits-7:0], 6'd0};
    end
    if (emit) begin
      out_char_q <= cur_char;
      out_last_q <= (idx_q == IdxLf);
    end
  end

endmodule

### tb/ais_position_report_nmea_encoder_tb.sv
// Testbench for the AIS position report encoder: directed table and random reports checked per byte.
module ais_position_report_nmea_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom  = 213;
  localparam int CalmTail   = 40;
  localparam int CycleLimit = 400000;
  localparam int DrainWait  = 60;
  localparam int NumRows    = 17;

  localparam logic [8*14-1:0] HeadText  = "!AIVDM,1,1,,A,";
  localparam logic [127:0]    HexDigits = "0123456789ABCDEF";
  localparam logic [8*47-1:0] ZeroLine  = "!AIVDM,1,1,,A,1000000000P00000000000000000,0*47";
  localparam logic [7:0]      CharCr    = 8'h0D;
  localparam logic [7:0]      CharLf    = 8'h0A;

  typedef struct packed {
    logic                typed;
    aisenc_pkg::report_t rpt;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } nmea_byte_t;

  // typed, utc_second, course_tenths, lat_units, lon_units, speed_tenths, vessel_id
  localparam dir_row_t DirRows [NumRows] = '{
    {1'b1, 6'd0, 12'd0, 27'sd0, 28'sd0, 16'd0, 30'd0},
    {1'b0, 6'd63, 12'd4095, 27'h3FFFFFF, 28'h7FFFFFF, 16'hFFFF, 30'h3FFFFFFF},
    {1'b0, 6'd0, 12'd0, 27'h4000000, 28'h8000000, 16'd0, 30'h2AAAAAAA},
    {1'b0, 6'd1, 12'd10, 27'sd0, 28'sd0, 16'd1022, 30'd1},
    {1'b0, 6'd2, 12'd9, 27'sd0, 28'sd0, 16'd1023, 30'h15555555},
    {1'b0, 6'd3, 12'd3599, 27'sd0, 28'sd108000000, 16'd1021, 30'd123456789},
    {1'b0, 6'd4, 12'd3600, 27'sd0, -28'sd108000000, 16'd1024, 30'd987654321},
    {1'b0, 6'd5, 12'd3601, 27'sd0, 28'sd108000001, 16'd7, 30'd2},
    {1'b0, 6'd6, 12'd3610, 27'sd0, -28'sd108000001, 16'd8, 30'd4},
    {1'b0, 6'd7, 12'd100, 27'sd54000000, 28'sd0, 16'd9, 30'd8},
    {1'b0, 6'd8, 12'd200, -27'sd54000000, 28'sd0, 16'd10, 30'd16},
    {1'b0, 6'd9, 12'd300, 27'sd54000001, 28'sd0, 16'd11, 30'd32},
    {1'b0, 6'd10, 12'd400, -27'sd54000001, 28'sd0, 16'd12, 30'd64},
    {1'b0, 6'd59, 12'd3590, -27'sd1, -28'sd1, 16'd512, 30'h20000000},
    {1'b0, 6'd60, 12'd1234, 27'sd123456, -28'sd654321, 16'd100, 30'd366123456},
    {1'b0, 6'd31, 12'd2048, 27'sd54600000, 28'sd108600000, 16'd1025, 30'h3FFFFFFE},
    {1'b0, 6'd32, 12'd1, 27'sd1, 28'sd1, 16'd1, 30'd211000000}
  };

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [7:0]   m_axis_tdata;
  logic         m_axis_tlast;

  nmea_byte_t expected_chars [$];
  int         err_count;
  int         cycle_count;
  int         char_pos;
  bit         calm;

  ais_position_report_nmea_encoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $realtime, what);
    err_count++;
  endtask

  function automatic void predict_sentence(input aisenc_pkg::report_t r);
    logic [9:0]   sog;
    logic [11:0]  cog;
    logic [8:0]   hdg;
    int           lon_i;
    int           lat_i;
    logic [167:0] msg;
    logic [5:0]   sixbit;
    logic [7:0]   line [49];
    logic [7:0]   sum;
    nmea_byte_t   nb;
    sog = (r.speed_tenths > 16'd1022) ? 10'd1023 : r.speed_tenths[9:0];
    lon_i = $signed(r.lon_units);
    lat_i = $signed(r.lat_units);
    if (lon_i < -108000000 || lon_i > 108000000) lon_i = 108600000;
    if (lat_i < -54000000 || lat_i > 54000000) lat_i = 54600000;
    cog = (r.course_tenths >= 12'd3600) ? 12'd3600 : r.course_tenths;
    hdg = 9'(r.course_tenths / 12'd10);
    if (hdg > 9'd359) hdg = 9'd511;
    msg = {6'd1, 2'd0, r.vessel_id, 4'd0, 8'd0, sog, 1'b1, lon_i[27:0], lat_i[26:0],
           cog, hdg, r.utc_second, 25'd0};
    for (int k = 0; k < 14; k++) line[k] = HeadText[8*(13-k) +: 8];
    for (int k = 0; k < 28; k++) begin
      sixbit = msg[167-6*k -: 6];
      line[14+k] = (sixbit < 6'd40) ? 8'(sixbit) + 8'd48 : 8'(sixbit) + 8'd56;
    end
    line[42] = ",";
    line[43] = "0";
    sum = 8'd0;
    for (int k = 1; k < 44; k++) sum ^= line[k];
    line[44] = "*";
    line[45] = HexDigits[8*(15-sum[7:4]) +: 8];
    line[46] = HexDigits[8*(15-sum[3:0]) +: 8];
    line[47] = CharCr;
    line[48] = CharLf;
    for (int k = 0; k < 49; k++) begin
      nb.ch   = line[k];
      nb.last = (k == 48);
      expected_chars = {expected_chars, nb};
    end
  endfunction

  task automatic send_report(input aisenc_pkg::report_t r, input bit typed);
    int         gap;
    nmea_byte_t nb;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {1'b0, r};
    do @(posedge clk_i); while (!s_axis_tready);
    if (typed) begin
      for (int k = 0; k < 47; k++) begin
        nb.ch   = ZeroLine[8*(46-k) +: 8];
        nb.last = 1'b0;
        expected_chars = {expected_chars, nb};
      end
      nb.ch   = CharCr;
      nb.last = 1'b0;
      expected_chars = {expected_chars, nb};
      nb.ch   = CharLf;
      nb.last = 1'b1;
      expected_chars = {expected_chars, nb};
    end else begin
      predict_sentence(r);
    end
  endtask

  task automatic drain_sentences();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
  endtask

  // receiver: stall in bursts, none in the calm tail
  initial begin
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall == 0 && !calm && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 6);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    nmea_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected word %02h last %b", m_axis_tdata, m_axis_tlast));
      end else begin
        want = expected_chars.pop_front();
        if (m_axis_tdata !== want.ch) begin
          report_mismatch($sformatf("byte %0d: char %02h, want %02h",
                                    char_pos, m_axis_tdata, want.ch));
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch($sformatf("byte %0d: last %b, want %b",
                                    char_pos, m_axis_tlast, want.last));
        end
      end
      char_pos = (char_pos == 48) ? 0 : char_pos + 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("ais_position_report_nmea_encoder: mismatch");
      $finish;
    end
  end

  initial begin
    aisenc_pkg::report_t rpt;
    int                  lon_i;
    int                  lat_i;
    err_count     = 0;
    cycle_count   = 0;
    char_pos      = 0;
    calm          = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NumRows; i++) send_report(DirRows[i].rpt, DirRows[i].typed);
    drain_sentences();

    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 2) drain_sentences();
      if (i == NumRandom - CalmTail) calm = 1'b1;
      rpt.vessel_id  = 30'($urandom);
      rpt.utc_second = 6'($urandom_range(0, 63));
      case ($urandom_range(0, 2))
        0:       rpt.speed_tenths = 16'($urandom_range(0, 1022));
        1:       rpt.speed_tenths = 16'($urandom_range(1019, 1026));
        default: rpt.speed_tenths = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 5))
        0, 1, 2: lon_i = int'($urandom_range(0, 216000000)) - 108000000;
        3:       lon_i = ($urandom_range(0, 1) ? 108000000 : -108000000)
                         + int'($urandom_range(0, 2)) - 1;
        default: lon_i = int'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0, 1, 2: lat_i = int'($urandom_range(0, 108000000)) - 54000000;
        3:       lat_i = ($urandom_range(0, 1) ? 54000000 : -54000000)
                         + int'($urandom_range(0, 2)) - 1;
        default: lat_i = int'($urandom);
      endcase
      rpt.lon_units = lon_i[27:0];
      rpt.lat_units = lat_i[26:0];
      case ($urandom_range(0, 2))
        0:       rpt.course_tenths = 12'($urandom_range(0, 3599));
        1:       rpt.course_tenths = 12'($urandom_range(3585, 3615));
        default: rpt.course_tenths = 12'($urandom_range(0, 4095));
      endcase
      send_report(rpt, 1'b0);
    end

    drain_sentences();
    repeat (DrainWait) @(posedge clk_i);
    if (err_count == 0) begin
      $display("ais_position_report_nmea_encoder: match");
    end else begin
      $display("ais_position_report_nmea_encoder: mismatch");
    end
    $finish;
  end

endmodule
